[design/spi_master_shifter_macros.svh]
// assertion macros for the spi master shifter
// used by spi_master_shifter.sv, expects clk and rst in scope
`ifndef SPI_MASTER_SHIFTER_MACROS_SVH
`define SPI_MASTER_SHIFTER_MACROS_SVH

// same-cycle implication
`define SMS_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// next-cycle implication
`define SMS_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

[design/spi_ms_pkg.sv]
// types and constants for the spi master shifter
// no dependencies
package spi_ms_pkg;

  // request kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // register indexes
  localparam logic [1:0] REG_CLOCK_MODE  = 2'd0;
  localparam logic [1:0] REG_WORD_SIZE   = 2'd1;
  localparam logic [1:0] REG_LSB_FIRST   = 2'd2;
  localparam logic [1:0] REG_PHASE_TICKS = 2'd3;

  // word size codes
  localparam logic [1:0] WS_16 = 2'd1;
  localparam logic [1:0] WS_32 = 2'd2;

  // bit phases
  localparam logic [1:0] PH_DRIVE  = 2'd0;
  localparam logic [1:0] PH_SAMPLE = 2'd1;
  localparam logic [1:0] PH_TRAIL  = 2'd2;

  localparam logic [1:0] CLK_MODE0 = 2'd0;
  localparam logic [1:0] CLK_MODE2 = 2'd2;

  typedef struct packed {
    logic        sclk_level;
    logic        mosi_level;
    logic        busy_res;
    logic        word_done;
    logic [31:0] rx_word;
    logic        load_rejected;
  } res_t;

endpackage

[design/spi_master_shifter.sv]
// spi master shifter, clock modes 0-3, paced by tick requests
// depends on spi_ms_pkg and spi_master_shifter_macros.svh
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | mode, tx_word, miso_level
//  out     | out_valid / out_stall| sclk_level, mosi_level, busy_res, word_done,
//          |                      | rx_word, load_rejected
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one request per cycle while in_stall is low; each request is worked in the cycle it is taken and
// its result is registered in the output register, or in the skid entry while the output stalls
// an output register plus one skid entry sit behind the logic, so a stalled
// output still lets one more request in; in_stall comes from the skid flag
// rst is synchronous: registers go to their listed values, sclk idles low
`include "spi_master_shifter_macros.svh"

module spi_master_shifter #(
  parameter int TICK_COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [31:0] tx_word,
  input  logic        miso_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sclk_level,
  output logic        mosi_level,
  output logic        busy_res,
  output logic        word_done,
  output logic [31:0] rx_word,
  output logic        load_rejected,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LW = ((TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16) + 1;
  localparam logic [LW-1:0] TICK_CAP = LW'(1) << TICK_COUNT_WIDTH;

  // configuration
  logic [1:0]  clock_mode;
  logic [1:0]  word_size;
  logic        lsb_first;
  logic [15:0] phase_ticks;

  // transfer state
  logic [31:0]                 tx_shift, tx_shift_next;
  logic [31:0]                 rx_shift, rx_shift_next;
  logic [5:0]                  bits_left, bits_left_next;
  logic [1:0]                  phase_index, phase_index_next;
  logic [TICK_COUNT_WIDTH-1:0] tick_counter, tick_counter_next;
  logic                        active, active_next;
  logic                        clock_line, clock_line_next;
  logic                        data_line, data_line_next;

  // output register and skid entry
  spi_ms_pkg::res_t out_res, skid_res, res;
  logic             skid_valid;

  logic        accept_in, cfg_fire, out_fire;
  logic        cpol, cpha;
  logic [5:0]  n_bits;
  logic [31:0] word_msk, top_bit;
  logic        msb_out;
  logic [LW-1:0] lim, tick_inc;
  logic [1:0]  ph_inc;
  logic        last_phase;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_stall  = skid_valid;
  assign accept_in = in_valid & ~skid_valid;
  assign out_fire  = out_valid & ~out_stall;

  assign cpol = clock_mode[1];
  assign cpha = clock_mode[0];

  always_comb begin
    unique case (word_size)
      spi_ms_pkg::WS_16: begin
        n_bits   = 6'd16;
        word_msk = 32'h0000_FFFF;
        top_bit  = 32'h0000_8000;
        msb_out  = tx_shift[15];
      end
      spi_ms_pkg::WS_32: begin
        n_bits   = 6'd32;
        word_msk = 32'hFFFF_FFFF;
        top_bit  = 32'h8000_0000;
        msb_out  = tx_shift[31];
      end
      default: begin
        n_bits   = 6'd8;
        word_msk = 32'h0000_00FF;
        top_bit  = 32'h0000_0080;
        msb_out  = tx_shift[7];
      end
    endcase
  end

  // phase length: zero acts as one, capped at the counter range
  always_comb begin
    lim = (phase_ticks == 16'd0) ? LW'(1) : LW'(phase_ticks);
    if (lim > TICK_CAP) begin
      lim = TICK_CAP;
    end
  end

  assign tick_inc = LW'(tick_counter) + LW'(1);
  assign ph_inc   = phase_index + 2'd1;
  assign last_phase = (ph_inc == 2'd0) ||
                      ((clock_mode == spi_ms_pkg::CLK_MODE0) ? (ph_inc >= 2'd3)
                                                             : (ph_inc >= 2'd2));

  always_comb begin
    tx_shift_next     = tx_shift;
    rx_shift_next     = rx_shift;
    bits_left_next    = bits_left;
    phase_index_next  = phase_index;
    tick_counter_next = tick_counter;
    active_next       = active;
    clock_line_next   = clock_line;
    data_line_next    = data_line;
    res               = '0;
    if (accept_in) begin
      if (mode == spi_ms_pkg::MODE_LOAD) begin
        if (active) begin
          res.load_rejected = 1'b1;
        end else begin
          tx_shift_next     = tx_word & word_msk;
          rx_shift_next     = '0;
          bits_left_next    = n_bits;
          phase_index_next  = spi_ms_pkg::PH_DRIVE;
          tick_counter_next = '0;
          active_next       = 1'b1;
        end
      end else if (active) begin
        // line action on the first tick of a phase
        if (tick_counter == '0) begin
          case (phase_index)
            spi_ms_pkg::PH_DRIVE: begin
              if (cpha) begin
                clock_line_next = ~cpol;
              end
              data_line_next = lsb_first ? tx_shift[0] : msb_out;
            end
            spi_ms_pkg::PH_SAMPLE: begin
              clock_line_next = ~(cpol ^ cpha);
              if (lsb_first) begin
                tx_shift_next = (tx_shift >> 1) & word_msk;
                rx_shift_next = ((rx_shift >> 1) | (miso_level ? top_bit : '0)) & word_msk;
              end else begin
                tx_shift_next = (tx_shift << 1) & word_msk;
                rx_shift_next = ((rx_shift << 1) | {31'd0, miso_level}) & word_msk;
              end
            end
            spi_ms_pkg::PH_TRAIL: begin
              if (clock_mode == spi_ms_pkg::CLK_MODE0) begin
                clock_line_next = 1'b0;
              end
            end
            default: ;
          endcase
        end
        if (tick_inc >= lim) begin
          tick_counter_next = '0;
          if (phase_index == spi_ms_pkg::PH_SAMPLE && clock_mode == spi_ms_pkg::CLK_MODE2) begin
            clock_line_next = 1'b1;
          end
          phase_index_next = ph_inc;
          if (last_phase) begin
            phase_index_next = spi_ms_pkg::PH_DRIVE;
            bits_left_next   = (bits_left != 6'd0) ? bits_left - 6'd1 : bits_left;
            if (bits_left_next == 6'd0) begin
              active_next     = 1'b0;
              res.word_done   = 1'b1;
              res.rx_word     = rx_shift_next & word_msk;
              clock_line_next = cpol;
            end
          end
        end else begin
          tick_counter_next = tick_inc[TICK_COUNT_WIDTH-1:0];
        end
      end
    end else if (cfg_fire && cfg_index == spi_ms_pkg::REG_CLOCK_MODE && !active) begin
      // idle clock repair
      clock_line_next = cfg_data[1];
    end
    res.sclk_level = clock_line_next;
    res.mosi_level = data_line_next;
    res.busy_res   = active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_mode  <= '0;
      word_size   <= '0;
      lsb_first   <= 1'b0;
      phase_ticks <= 16'd1;
    end else if (cfg_fire) begin
      case (cfg_index)
        spi_ms_pkg::REG_CLOCK_MODE:  clock_mode  <= cfg_data[1:0];
        spi_ms_pkg::REG_WORD_SIZE:   word_size   <= cfg_data[1:0];
        spi_ms_pkg::REG_LSB_FIRST:   lsb_first   <= cfg_data[0];
        spi_ms_pkg::REG_PHASE_TICKS: phase_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift     <= '0;
      rx_shift     <= '0;
      bits_left    <= '0;
      phase_index  <= '0;
      tick_counter <= '0;
      active       <= 1'b0;
      clock_line   <= 1'b0;
      data_line    <= 1'b0;
    end else begin
      tx_shift     <= tx_shift_next;
      rx_shift     <= rx_shift_next;
      bits_left    <= bits_left_next;
      phase_index  <= phase_index_next;
      tick_counter <= tick_counter_next;
      active       <= active_next;
      clock_line   <= clock_line_next;
      data_line    <= data_line_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept_in;
      end
    end else if (accept_in) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire || !out_valid) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept_in) begin
        out_res <= res;
      end
    end else if (accept_in) begin
      skid_res <= res;
    end
  end

  assign sclk_level    = out_res.sclk_level;
  assign mosi_level    = out_res.mosi_level;
  assign busy_res      = out_res.busy_res;
  assign word_done     = out_res.word_done;
  assign rx_word       = out_res.rx_word;
  assign load_rejected = out_res.load_rejected;

  `SMS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry held without output")
  `SMS_ASSERT_NOW(a_idle_no_bits, !active, bits_left == 6'd0, "idle with bits left")
  `SMS_ASSERT_NOW(a_done_not_busy, out_valid && word_done, !busy_res, "word done while busy")
  `SMS_ASSERT_NEXT(a_load_starts, accept_in && mode == spi_ms_pkg::MODE_LOAD && !active, active, "load did not start transfer")

endmodule

[tb/spi_master_shifter_test.sv]
`timescale 1ns / 100ps
// self-checking testbench for spi_master_shifter: directed table, then random words
// depends on spi_ms_pkg and the spi_master_shifter rtl
module spi_master_shifter_test;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_STOP = 400;
  localparam int TAIL_CYCLES = 8;
  localparam int N_ROWS = 28;

  typedef struct packed {
    bit               is_reg;
    logic [1:0]       reg_idx;
    logic [15:0]      reg_val;
    logic             m;
    logic [31:0]      w;
    logic             s;
    bit               typed;
    spi_ms_pkg::res_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = spi_ms_pkg::MODE_LOAD;
  logic [31:0] tx_word = '0;
  logic        miso_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        sclk_level;
  logic        mosi_level;
  logic        busy_res;
  logic        word_done;
  logic [31:0] rx_word;
  logic        load_rejected;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // shifter model: registers and transfer state
  logic [1:0]  reg_clock_mode = 2'd0;
  logic [1:0]  reg_word_size = 2'd0;
  logic        reg_lsb_first = 1'b0;
  logic [15:0] reg_phase_ticks = 16'd1;
  logic [31:0] tx_sh = '0;
  logic [31:0] rx_sh = '0;
  logic [5:0]  bits_left = '0;
  logic [1:0]  phase_idx = spi_ms_pkg::PH_DRIVE;
  logic [15:0] tick_cnt = '0;
  logic        sh_busy = 1'b0;
  logic        sclk_q = 1'b0;
  logic        mosi_q = 1'b0;

  spi_ms_pkg::res_t pending_results [$];
  int          item_count = 0;
  int          fail_count = 0;
  int          cycle_count = 0;
  stim_row_t   directed_rows [N_ROWS];
  logic [15:0] reg_vals [4];

  // one stretch of requests with no idling on either side
  wire steady = (item_count >= 200) && (item_count < 300);

  always #1 clk = ~clk;

  spi_master_shifter i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .tx_word       (tx_word),
    .miso_level    (miso_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sclk_level    (sclk_level),
    .mosi_level    (mosi_level),
    .busy_res      (busy_res),
    .word_done     (word_done),
    .rx_word       (rx_word),
    .load_rejected (load_rejected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  function automatic int word_len(logic [1:0] ws);
    case (ws)
      spi_ms_pkg::WS_16: return 16;
      spi_ms_pkg::WS_32: return 32;
      default:           return 8;
    endcase
  endfunction

  function automatic logic [31:0] low_mask(int n);
    return (n >= 32) ? 32'hFFFF_FFFF : ((32'h1 << n) - 32'h1);
  endfunction

  function automatic stim_row_t tick_row(logic s);
    stim_row_t r;
    r = '0;
    r.m = spi_ms_pkg::MODE_TICK;
    r.s = s;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [1:0] idx, logic [15:0] v);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic m, logic [31:0] w, spi_ms_pkg::res_t want);
    stim_row_t r;
    r = '0;
    r.m = m;
    r.w = w;
    r.typed = 1'b1;
    r.want = want;
    return r;
  endfunction

  task automatic apply_reg(input logic [1:0] idx, input logic [15:0] v);
    case (idx)
      spi_ms_pkg::REG_CLOCK_MODE: begin
        reg_clock_mode = v[1:0];
        // idle clock follows the new polarity at once
        if (!sh_busy) sclk_q = v[1];
      end
      spi_ms_pkg::REG_WORD_SIZE: reg_word_size = v[1:0];
      spi_ms_pkg::REG_LSB_FIRST: reg_lsb_first = v[0];
      default: reg_phase_ticks = v;
    endcase
  endtask

  task automatic advance_shifter(input logic m, input logic [31:0] w, input logic s,
                                 output spi_ms_pkg::res_t r);
    int n;
    int limit;
    int nphases;
    r = '0;
    n = word_len(reg_word_size);
    nphases = (reg_clock_mode == spi_ms_pkg::CLK_MODE0) ? 3 : 2;
    if (m == spi_ms_pkg::MODE_LOAD) begin
      if (sh_busy) begin
        r.load_rejected = 1'b1;
      end else begin
        tx_sh = w & low_mask(n);
        rx_sh = '0;
        bits_left = 6'(n);
        phase_idx = spi_ms_pkg::PH_DRIVE;
        tick_cnt = '0;
        sh_busy = 1'b1;
      end
    end else if (sh_busy) begin
      // line action on the first tick of each phase
      if (tick_cnt == '0) begin
        case (phase_idx)
          spi_ms_pkg::PH_DRIVE: begin
            if (reg_clock_mode[0]) sclk_q = ~reg_clock_mode[1];
            mosi_q = reg_lsb_first ? tx_sh[0] : tx_sh[n-1];
          end
          spi_ms_pkg::PH_SAMPLE: begin
            sclk_q = ~(reg_clock_mode[1] ^ reg_clock_mode[0]);
            if (reg_lsb_first) begin
              tx_sh = tx_sh >> 1;
              rx_sh = (rx_sh >> 1) | (s ? (32'h1 << (n - 1)) : 32'h0);
            end else begin
              tx_sh = tx_sh << 1;
              rx_sh = {rx_sh[30:0], s};
            end
            tx_sh &= low_mask(n);
            rx_sh &= low_mask(n);
          end
          spi_ms_pkg::PH_TRAIL: begin
            if (reg_clock_mode == spi_ms_pkg::CLK_MODE0) sclk_q = 1'b0;
          end
          default: ;
        endcase
      end
      limit = (reg_phase_ticks == '0) ? 1 : int'(reg_phase_ticks);
      if (int'(tick_cnt) + 1 >= limit) begin
        tick_cnt = '0;
        if (phase_idx == spi_ms_pkg::PH_SAMPLE && reg_clock_mode == spi_ms_pkg::CLK_MODE2)
          sclk_q = 1'b1;
        phase_idx = phase_idx + 2'd1;
        // a phase left over from an earlier mode ends the bit too
        if (int'(phase_idx) >= nphases || phase_idx == spi_ms_pkg::PH_DRIVE) begin
          phase_idx = spi_ms_pkg::PH_DRIVE;
          if (bits_left != '0) bits_left = bits_left - 6'd1;
          if (bits_left == '0) begin
            sh_busy = 1'b0;
            r.word_done = 1'b1;
            r.rx_word = rx_sh & low_mask(n);
            sclk_q = reg_clock_mode[1];
          end
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
      end
    end
    r.sclk_level = sclk_q;
    r.mosi_level = mosi_q;
    r.busy_res = sh_busy;
  endtask

  task automatic send_request(input logic m, input logic [31:0] w, input logic s,
                              input bit typed, input spi_ms_pkg::res_t typed_res);
    spi_ms_pkg::res_t predicted;
    while (!steady && $urandom_range(0, 99) < 14) begin
      if (in_valid) in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    tx_word <= w;
    miso_level <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    advance_shifter(m, w, s, predicted);
    pending_results.push_back(typed ? typed_res : predicted);
    item_count++;
  endtask

  task automatic drain;
    if (in_valid) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] vals [4], input logic [3:0] sel);
    for (int i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= 2'(i);
        cfg_data <= vals[i];
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        apply_reg(2'(i), vals[i]);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_words;
    int pick;
    logic [1:0] idx;
    while (item_count < RANDOM_STOP) begin
      drain;
      pick = $urandom_range(0, 19);
      reg_vals[spi_ms_pkg::REG_CLOCK_MODE] = 16'($urandom_range(0, 3));
      reg_vals[spi_ms_pkg::REG_WORD_SIZE] =
        (pick < 12) ? 16'd0 : (pick < 15) ? 16'd3 :
        (pick < 18) ? 16'(spi_ms_pkg::WS_16) : 16'(spi_ms_pkg::WS_32);
      reg_vals[spi_ms_pkg::REG_LSB_FIRST] = 16'($urandom_range(0, 1));
      reg_vals[spi_ms_pkg::REG_PHASE_TICKS] = ($urandom_range(0, 9) < 7 || pick >= 18) ?
                                  16'($urandom_range(0, 1)) : 16'($urandom_range(2, 4));
      program_regs(reg_vals, 4'b1111);
      repeat ($urandom_range(1, 4)) begin
        // stray tick on an idle line
        if ($urandom_range(0, 4) == 0)
          send_request(spi_ms_pkg::MODE_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
        send_request(spi_ms_pkg::MODE_LOAD, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
        while (sh_busy) begin
          if ($urandom_range(0, 99) < 2) begin
            // register change in the middle of a word
            drain;
            idx = 2'($urandom_range(0, 3));
            reg_vals[idx] = (idx == spi_ms_pkg::REG_LSB_FIRST) ? 16'($urandom_range(0, 1)) :
                            (idx == spi_ms_pkg::REG_PHASE_TICKS) ? 16'($urandom_range(0, 4)) :
                            16'($urandom_range(0, 3));
            program_regs(reg_vals, 4'b0001 << idx);
          end
          if ($urandom_range(0, 99) < 6)
            send_request(spi_ms_pkg::MODE_LOAD, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
          else
            send_request(spi_ms_pkg::MODE_TICK, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    spi_ms_pkg::res_t got;
    spi_ms_pkg::res_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{sclk_level, mosi_level, busy_res, word_done, rx_word, load_rejected};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 40) $display("%0t: result with no request waiting", $time);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 40)
            $display("%0t: expected sclk=%b mosi=%b busy=%b done=%b rx=%h rej=%b, got sclk=%b mosi=%b busy=%b done=%b rx=%h rej=%b",
                     $time, want.sclk_level, want.mosi_level, want.busy_res,
                     want.word_done, want.rx_word, want.load_rejected,
                     got.sclk_level, got.mosi_level, got.busy_res,
                     got.word_done, got.rx_word, got.load_rejected);
        end
      end
    end
    out_stall <= rst ? 1'b0 : (!steady && $urandom_range(0, 99) < 14);
  end

  initial begin
    // no two register rows in a row: program_regs lowers cfg_valid on its way out
    directed_rows = '{
      typed_row(spi_ms_pkg::MODE_TICK, 32'h0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b0}),
      typed_row(spi_ms_pkg::MODE_LOAD, 32'hFFFF_FFFF, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b0}),
      typed_row(spi_ms_pkg::MODE_LOAD, 32'h0, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}),
      tick_row(1'b1), tick_row(1'b0),
      // switch to mode 3 while parked in the trailing phase
      reg_row(spi_ms_pkg::REG_CLOCK_MODE, 16'd3),
      tick_row(1'b1),
      reg_row(spi_ms_pkg::REG_PHASE_TICKS, 16'hFFFF),
      tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
      // zero acts as one tick, cutting the long phase short
      reg_row(spi_ms_pkg::REG_PHASE_TICKS, 16'd0),
      tick_row(1'b1), tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
      tick_row(1'b1), tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
      tick_row(1'b1), tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
      tick_row(1'b1), tick_row(1'b0),
      reg_row(spi_ms_pkg::REG_CLOCK_MODE, 16'd2),
      tick_row(1'b0)
    };
    reg_vals = '{16'd0, 16'd0, 16'd0, 16'd1};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        drain;
        reg_vals[directed_rows[i].reg_idx] = directed_rows[i].reg_val;
        program_regs(reg_vals, 4'b0001 << directed_rows[i].reg_idx);
      end else begin
        send_request(directed_rows[i].m, directed_rows[i].w, directed_rows[i].s,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end
    random_words();
    drain;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
